// ----- design/hubbard_local_flip_green_update_unit_assert.svh -----
// ----------------------------------------------------------------------------
// hlfg assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled during reset;
// they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef HUBBARD_LOCAL_FLIP_GREEN_UPDATE_UNIT_ASSERT_SVH
`define HUBBARD_LOCAL_FLIP_GREEN_UPDATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define HLFG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen
`define HLFG_ASSERT_NEVER(lbl, cond, msg) \
  `HLFG_ASSERT(lbl, !(cond), msg)
`else
`define HLFG_ASSERT(lbl, prop, msg)
`define HLFG_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- design/hlfg_pkg.sv -----
// ----------------------------------------------------------------------------
// hlfg_pkg
// Types, codes and fixed-point helpers of the local flip Green update unit.
// ----------------------------------------------------------------------------
package hlfg_pkg;

  localparam int DEF_SITES       = 64;
  localparam int DEF_TIME_SLICES = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int DIV_STEPS       = 56;
  localparam int DIV_CW          = 6;

  localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    FN_WR_ENTRY = 3'd0,
    FN_WR_FIELD = 3'd1,
    FN_PROPOSE  = 3'd2,
    FN_ACCEPT   = 3'd3,
    FN_RD_ENTRY = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_DIFF = 2'd0,
    CFG_AVERAGE   = 2'd1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_RDW, S_EF, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_DIV, S_DIVF, S_CPY, S_FC0, S_FC1, S_FC2, S_UPD, S_FLIP, S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         func;
    logic               spin_select;
    logic [5:0]         slice;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] entry_value;
    logic               field_bit;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] ratio;
    logic signed [31:0] read_data;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          value;
  } cfg_t;

  // clamped value with its saturation flag
  typedef struct packed {
    logic               sat;
    logic signed [31:0] v;
  } q_t;

  function automatic logic signed [33:0] sx(input logic signed [31:0] x);
    return {{2{x[31]}}, x};
  endfunction

  // clamp a 34-bit sum to the 32-bit range
  function automatic q_t sat34(input logic signed [33:0] x);
    q_t r;
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
      r.sat = 1'b0;
      r.v   = x[31:0];
    end else begin
      r.sat = 1'b1;
      r.v   = x[33] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

  // product scaled by 2^-24, truncated toward zero, then clamped
  function automatic q_t qtrunc(input logic signed [63:0] p);
    logic signed [39:0] t;
    q_t                 r;
    t = p[63:24];
    if (p[63] && (|p[23:0])) t = t + 40'sd1;
    if ((&t[39:31]) || !(|t[39:31])) begin
      r.sat = 1'b0;
      r.v   = t[31:0];
    end else begin
      r.sat = 1'b1;
      r.v   = t[39] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

endpackage

// ----- design/hlfg_stream_if.sv -----
// ----------------------------------------------------------------------------
// hlfg channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface hlfg_in_if;
  logic          valid;
  logic          ready;
  hlfg_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hlfg_out_if;
  logic           valid;
  logic           ready;
  hlfg_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hlfg_cfg_if;
  logic           valid;
  logic           ready;
  hlfg_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/hubbard_local_flip_green_update_unit.sv -----
// ----------------------------------------------------------------------------
// hubbard_local_flip_green_update_unit
// Up/down Green matrices and auxiliary field with flip proposal and
// rank-one update, one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// channel  dir  beat
// cfg_i    in   register index and value, always ready
// in_i     in   one item (func, spin, slice, row, col, value, field bit)
// out_o    out  one result per item (kind, ratio, read data, flag)
//
// propose runs the 56-step divider; accept streams one matrix entry per
// cycle through the shared multiplier. matrices and field have no reset
// and read undefined until loaded. in_i is ready only when idle; a waiting
// result is held in the output register and stalls only at the next
// result.
// ----------------------------------------------------------------------------
`include "hubbard_local_flip_green_update_unit_assert.svh"

module hubbard_local_flip_green_update_unit #(
  parameter int SITES       = hlfg_pkg::DEF_SITES,
  parameter int TIME_SLICES = hlfg_pkg::DEF_TIME_SLICES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hlfg_cfg_if.sink   cfg_i,
  hlfg_in_if.sink    in_i,
  hlfg_out_if.source out_o
);
  import hlfg_pkg::*;

  localparam int SS  = SITES * SITES;
  localparam int GD  = 2 * SS;
  localparam int GAW = $clog2(GD);
  localparam int FD  = TIME_SLICES * SITES;
  localparam int FAW = (FD > 1) ? $clog2(FD) : 1;
  localparam int SW  = (SITES > 1) ? $clog2(SITES) : 1;
  localparam int CW  = $clog2(SITES + 1);

  function automatic logic [GAW-1:0] gaddr(input logic sp, input int r, input int c);
    return GAW'(int'(sp) * SS + r * SITES + c);
  endfunction

  // control and datapath registers
  state_e             state_q, state_d;
  in_t                item_q, item_d;
  logic signed [31:0] hd_q, avg_q;
  logic               sat_q, sat_d;
  logic signed [31:0] ratio_q, ratio_d, rdata_q, rdata_d;
  logic signed [31:0] ef_q, ef_d, delta_q, delta_d;
  logic signed [31:0] umu_q, umu_d, umd_q, umd_d;
  logic signed [31:0] detu_q, detu_d, tmp_q, tmp_d;
  logic               fbit_q, fbit_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] factor_q, factor_d, fc_q, fc_d;
  logic [31:0]        rem_q, rem_d, dvs_q, dvs_d;
  logic [55:0]        dend_q, dend_d;
  logic               neg_q, neg_d, dz_q, dz_d;
  logic [DIV_CW-1:0]  cnt_q, cnt_d;
  logic               spin_q, spin_d;
  logic [CW-1:0]      a_q, a_d, b_q, b_d;
  logic               cp_v_q, cp_v_d;
  logic [SW-1:0]      cp_i_q, cp_i_d;
  logic               p1_v_q, p1_v_d, p2_v_q, p2_v_d;
  logic [SW-1:0]      p1_b_q, p1_b_d;
  logic [GAW-1:0]     p1_addr_q, p1_addr_d, p2_addr_q, p2_addr_d;
  logic signed [31:0] gold_q, gold_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  // memory ports
  logic               g_we;
  logic [GAW-1:0]     g_wa, g_ra, g_rb;
  logic signed [31:0] g_wd, ga_rd_q, gb_rd_q;
  logic               f_we, f_wd, f_rd_q;
  logic [FAW-1:0]     f_wa, f_ra;
  logic               c_we;
  logic [SW-1:0]      c_wa, c_ra, r_ra;
  logic signed [31:0] c_wcol, c_wrow, colc_rd_q, rowc_rd_q;

  logic signed [31:0] green_mem [GD];
  logic               aux_mem   [FD];
  logic signed [31:0] colc_mem  [SITES];
  logic signed [31:0] rowc_mem  [SITES];

  // divider launch
  logic               div_go;
  logic signed [31:0] div_num, div_den;

  logic           row_ok, col_ok, slice_ok, is_prop;
  logic [SW-1:0]  row_i;
  logic [FAW-1:0] fi;

  assign row_ok   = int'(item_q.row) < SITES;
  assign col_ok   = int'(item_q.col) < SITES;
  assign slice_ok = int'(item_q.slice) < TIME_SLICES;
  assign is_prop  = item_q.func == FN_PROPOSE;
  assign row_i    = SW'(item_q.row);
  assign fi       = FAW'(int'(item_q.slice) * SITES + int'(item_q.row));

  assign in_i.ready  = state_q == S_IDLE;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // memories
  always_ff @(posedge clk_i) begin
    if (g_we) green_mem[g_wa] <= g_wd;
    ga_rd_q <= green_mem[g_ra];
    gb_rd_q <= green_mem[g_rb];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) aux_mem[f_wa] <= f_wd;
    f_rd_q <= aux_mem[f_ra];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      colc_mem[c_wa] <= c_wcol;
      rowc_mem[c_wa] <= c_wrow;
    end
    colc_rd_q <= colc_mem[c_ra];
    rowc_rd_q <= rowc_mem[r_ra];
  end

  // shared multiplier
  assign prod_d = 64'(mul_a) * 64'(mul_b);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_q  <= '0;
      avg_q <= Q_ONE;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_HALF_DIFF: hd_q  <= cfg_i.data.value;
        CFG_AVERAGE:   avg_q <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      cp_v_q      <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      cp_v_q      <= cp_v_d;
      p1_v_q      <= p1_v_d;
      p2_v_q      <= p2_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    sat_q     <= sat_d;
    ratio_q   <= ratio_d;
    rdata_q   <= rdata_d;
    ef_q      <= ef_d;
    delta_q   <= delta_d;
    umu_q     <= umu_d;
    umd_q     <= umd_d;
    detu_q    <= detu_d;
    tmp_q     <= tmp_d;
    fbit_q    <= fbit_d;
    prod_q    <= prod_d;
    factor_q  <= factor_d;
    fc_q      <= fc_d;
    rem_q     <= rem_d;
    dvs_q     <= dvs_d;
    dend_q    <= dend_d;
    neg_q     <= neg_d;
    dz_q      <= dz_d;
    spin_q    <= spin_d;
    a_q       <= a_d;
    b_q       <= b_d;
    cp_i_q    <= cp_i_d;
    p1_b_q    <= p1_b_d;
    p1_addr_q <= p1_addr_d;
    p2_addr_q <= p2_addr_d;
    gold_q    <= gold_d;
    out_q     <= out_d;
  end

  // sequencer
  always_comb begin
    q_t                 qa, qb, qc;
    logic signed [33:0] hd34;
    logic [32:0]        rs;
    logic               ge;
    logic [31:0]        mag;
    logic signed [31:0] res;

    state_d     = state_q;
    item_d      = item_q;
    sat_d       = sat_q;
    ratio_d     = ratio_q;
    rdata_d     = rdata_q;
    ef_d        = ef_q;
    delta_d     = delta_q;
    umu_d       = umu_q;
    umd_d       = umd_q;
    detu_d      = detu_q;
    tmp_d       = tmp_q;
    fbit_d      = fbit_q;
    factor_d    = factor_q;
    fc_d        = fc_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    dend_d      = dend_q;
    neg_d       = neg_q;
    dz_d        = dz_q;
    cnt_d       = cnt_q;
    spin_d      = spin_q;
    a_d         = a_q;
    b_d         = b_q;
    cp_v_d      = 1'b0;
    cp_i_d      = cp_i_q;
    p1_v_d      = 1'b0;
    p1_b_d      = p1_b_q;
    p1_addr_d   = p1_addr_q;
    p2_v_d      = 1'b0;
    p2_addr_d   = p2_addr_q;
    gold_d      = gold_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    mul_a       = '0;
    mul_b       = '0;
    g_we        = 1'b0;
    g_wa        = '0;
    g_wd        = '0;
    g_ra        = '0;
    g_rb        = '0;
    f_we        = 1'b0;
    f_wa        = fi;
    f_wd        = 1'b0;
    f_ra        = fi;
    c_we        = 1'b0;
    c_wa        = cp_i_q;
    c_wcol      = ga_rd_q;
    c_wrow      = gb_rd_q;
    c_ra        = '0;
    r_ra        = '0;
    div_go      = 1'b0;
    div_num     = '0;
    div_den     = '0;
    qa          = '0;
    qb          = '0;
    qc          = '0;
    hd34        = '0;
    rs          = '0;
    ge          = 1'b0;
    mag         = '0;
    res         = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          item_d  = in_i.data;
          sat_d   = 1'b0;
          ratio_d = '0;
          rdata_d = '0;
          state_d = S_DISP;
        end
      end

      // decode the item and start its memory accesses
      S_DISP: begin
        state_d = S_DONE;
        unique case (item_q.func)
          FN_WR_ENTRY: begin
            if (row_ok && col_ok) begin
              g_we = 1'b1;
              g_wa = gaddr(item_q.spin_select, int'(item_q.row), int'(item_q.col));
              g_wd = item_q.entry_value;
            end
          end
          FN_RD_ENTRY: begin
            g_ra = gaddr(item_q.spin_select, int'(item_q.row), int'(item_q.col));
            if (row_ok && col_ok) state_d = S_RDW;
          end
          FN_WR_FIELD: begin
            if (row_ok && slice_ok) begin
              f_we = 1'b1;
              f_wd = item_q.field_bit;
            end
          end
          FN_PROPOSE, FN_ACCEPT: begin
            g_ra = gaddr(1'b0, int'(item_q.row), int'(item_q.row));
            g_rb = gaddr(1'b1, int'(item_q.row), int'(item_q.row));
            if (row_ok && slice_ok) state_d = S_EF;
          end
          default: ;
        endcase
      end

      S_RDW: begin
        rdata_d = ga_rd_q;
        state_d = S_DONE;
      end

      // exponential factor, delta and diagonal complements
      S_EF: begin
        fbit_d  = f_rd_q;
        hd34    = f_rd_q ? sx(hd_q) : -sx(hd_q);
        qa      = sat34(hd34 + sx(avg_q));
        qb      = sat34(sx(qa.v) - sx(Q_ONE));
        qc      = sat34(sx(Q_ONE) - sx(ga_rd_q));
        ef_d    = qa.v;
        delta_d = qb.v;
        umu_d   = qc.v;
        sat_d   = sat_q | qa.sat | qb.sat | qc.sat;
        qa      = sat34(sx(Q_ONE) - sx(gb_rd_q));
        umd_d   = qa.v;
        if (is_prop) sat_d = sat_d | qa.sat;
        state_d = S_M1;
      end

      S_M1: begin
        mul_a   = umu_q;
        mul_b   = delta_q;
        state_d = S_M2;
      end

      // up determinant ratio
      S_M2: begin
        qa     = qtrunc(prod_q);
        qb     = sat34(sx(Q_ONE) + sx(qa.v));
        detu_d = qb.v;
        sat_d  = sat_q | qa.sat | qb.sat;
        mul_a  = umd_q;
        mul_b  = delta_q;
        if (is_prop) begin
          state_d = S_M3;
        end else begin
          div_go  = 1'b1;
          div_num = delta_q;
          div_den = qb.v;
        end
      end

      // down determinant ratio
      S_M3: begin
        qa      = qtrunc(prod_q);
        qb      = sat34(sx(Q_ONE) + sx(qa.v));
        tmp_d   = qb.v;
        sat_d   = sat_q | qa.sat | qb.sat;
        state_d = S_M4;
      end

      S_M4: begin
        mul_a   = detu_q;
        mul_b   = tmp_q;
        state_d = S_M5;
      end

      S_M5: begin
        qa      = qtrunc(prod_q);
        sat_d   = sat_q | qa.sat;
        div_go  = 1'b1;
        div_num = qa.v;
        div_den = ef_q;
      end

      // one restoring quotient bit per cycle
      S_DIV: begin
        rs     = {rem_q, dend_q[55]};
        ge     = rs >= {1'b0, dvs_q};
        rem_d  = ge ? 32'(rs - {1'b0, dvs_q}) : rs[31:0];
        dend_d = {dend_q[54:0], ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_DIVF;
        end
      end

      // sign and clamp the quotient
      S_DIVF: begin
        if (dz_q) begin
          res = neg_q ? Q_MIN : Q_MAX;
        end else if (neg_q) begin
          if (dend_q > 56'd2147483648) begin
            res   = Q_MIN;
            sat_d = 1'b1;
          end else begin
            res = -$signed(dend_q[31:0]);
          end
        end else begin
          if (dend_q > 56'd2147483647) begin
            res   = Q_MAX;
            sat_d = 1'b1;
          end else begin
            res = dend_q[31:0];
          end
        end
        if (is_prop) begin
          ratio_d = res;
          state_d = S_DONE;
        end else begin
          factor_d = res;
          spin_d   = 1'b0;
          b_d      = '0;
          state_d  = S_CPY;
        end
      end

      // copy column i and row i of the current matrix
      S_CPY: begin
        if (int'(b_q) < SITES) begin
          g_ra   = gaddr(spin_q, int'(b_q), int'(row_i));
          g_rb   = gaddr(spin_q, int'(row_i), int'(b_q));
          cp_v_d = 1'b1;
          cp_i_d = SW'(b_q);
          b_d    = b_q + 1'b1;
        end else begin
          a_d     = '0;
          state_d = S_FC0;
        end
        if (cp_v_q) c_we = 1'b1;
      end

      S_FC0: begin
        c_ra    = SW'(a_q);
        b_d     = '0;
        state_d = S_FC1;
      end

      S_FC1: begin
        mul_a   = factor_q;
        mul_b   = colc_rd_q;
        state_d = S_FC2;
      end

      S_FC2: begin
        qa      = qtrunc(prod_q);
        fc_d    = qa.v;
        sat_d   = sat_q | qa.sat;
        state_d = S_UPD;
      end

      // stream one row: read, multiply, subtract and write back
      S_UPD: begin
        if (int'(b_q) < SITES) begin
          g_ra      = gaddr(spin_q, int'(a_q), int'(b_q));
          r_ra      = SW'(b_q);
          p1_v_d    = 1'b1;
          p1_b_d    = SW'(b_q);
          p1_addr_d = gaddr(spin_q, int'(a_q), int'(b_q));
          b_d       = b_q + 1'b1;
        end
        if (p1_v_q) begin
          qa        = sat34(((p1_b_q == row_i) ? sx(Q_ONE) : 34'sd0) - sx(rowc_rd_q));
          mul_a     = fc_q;
          mul_b     = qa.v;
          gold_d    = ga_rd_q;
          p2_v_d    = 1'b1;
          p2_addr_d = p1_addr_q;
          sat_d     = sat_d | qa.sat;
        end
        if (p2_v_q) begin
          qb    = qtrunc(prod_q);
          qc    = sat34(sx(gold_q) - sx(qb.v));
          g_we  = 1'b1;
          g_wa  = p2_addr_q;
          g_wd  = qc.v;
          sat_d = sat_d | qb.sat | qc.sat;
        end
        if (int'(b_q) == SITES && !p1_v_q && !p2_v_q) begin
          if (int'(a_q) == SITES - 1) begin
            if (!spin_q) begin
              spin_d  = 1'b1;
              b_d     = '0;
              state_d = S_CPY;
            end else begin
              state_d = S_FLIP;
            end
          end else begin
            a_d     = a_q + 1'b1;
            state_d = S_FC0;
          end
        end
      end

      S_FLIP: begin
        f_we    = 1'b1;
        f_wd    = ~fbit_q;
        state_d = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d     = 1'b1;
          out_d.kind      = item_q.func;
          out_d.ratio     = ratio_q;
          out_d.read_data = rdata_q;
          out_d.saturated = sat_q;
          state_d         = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // divider launch, zero divisor answered at once
    if (div_go) begin
      if (div_den == '0) begin
        dz_d    = 1'b1;
        neg_d   = div_num[31];
        sat_d   = 1'b1;
        state_d = S_DIVF;
      end else begin
        mag     = div_num[31] ? 32'(-div_num) : div_num;
        dend_d  = {mag, 24'd0};
        dvs_d   = div_den[31] ? 32'(-div_den) : div_den;
        rem_d   = '0;
        cnt_d   = '0;
        dz_d    = 1'b0;
        neg_d   = div_num[31] ^ div_den[31];
        state_d = S_DIV;
      end
    end
  end

  // checks
  `HLFG_ASSERT(a_div_cnt_idle, (state_q != S_DIV) |-> (cnt_q == '0), "divider count off")
  `HLFG_ASSERT(a_green_wr_state, g_we |-> (state_q == S_DISP || state_q == S_UPD), "stray write")
  `HLFG_ASSERT(a_one_item, (in_i.valid && in_i.ready) |=> !in_i.ready, "item overlap")
  `HLFG_ASSERT(a_pipe_order, p2_v_q |-> $past(p1_v_q), "update pipe out of order")
  `HLFG_ASSERT_NEVER(a_copy_state, cp_v_q && (state_q != S_CPY), "copy beat outside copy")

endmodule
